[rtl/core/modular_power_and_inverse_defines.svh]
// Assertion macros for the modular power and inverse block.
`ifndef MODULAR_POWER_AND_INVERSE_DEFINES_SVH
`define MODULAR_POWER_AND_INVERSE_DEFINES_SVH

// Clocked assertion, disabled in reset.
`define MPI_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define MPI_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/mpi_pkg.sv]
// ----------------------------------------------------------------------------
// mpi_pkg
// Types and constants shared by the modular power and inverse block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package mpi_pkg;

  localparam int unsigned FieldBits = 63;
  localparam int unsigned ModBits   = 32;
  localparam int unsigned DivBits   = 64;
  localparam logic [ModBits-1:0] ModulusReset = 32'd1000000007;

  localparam logic ModePower   = 1'b0;
  localparam logic ModeInverse = 1'b1;

  typedef struct packed {
    logic                 mode;
    logic [FieldBits-1:0] value;
    logic [FieldBits-1:0] exponent;
  } req_t;

  typedef struct packed {
    logic [ModBits-1:0] result;
    logic               no_inverse;
  } rsp_t;

  typedef struct packed {
    logic               done;
    logic [DivBits-1:0] quo;
    logic [ModBits-1:0] rem;
  } div_res_t;

endpackage
`default_nettype wire

[rtl/core/mpi_div.sv]
// ----------------------------------------------------------------------------
// mpi_div
// Restoring divider, one quotient bit per cycle: 64-bit by 32-bit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module mpi_div (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [mpi_pkg::DivBits-1:0]    dividend,
  input  wire logic [mpi_pkg::ModBits-1:0]    divisor,
  output mpi_pkg::div_res_t                   res
);

  localparam int unsigned CntBits = $clog2(mpi_pkg::DivBits);
  localparam logic [CntBits-1:0] LastCnt = CntBits'(mpi_pkg::DivBits - 1);

  logic                         busy;
  logic                         done;
  logic [CntBits-1:0]           cnt;
  logic [mpi_pkg::DivBits-1:0]  dq;
  logic [mpi_pkg::ModBits-1:0]  rem;
  logic [mpi_pkg::ModBits-1:0]  dvs;
  logic [mpi_pkg::ModBits:0]    trial;
  logic                         fits;

  assign trial = {rem, dq[mpi_pkg::DivBits-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && !start && (cnt == LastCnt);
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        dq   <= dividend;
        rem  <= '0;
        dvs  <= divisor;
      end else if (busy) begin
        rem <= fits ? mpi_pkg::ModBits'(trial - {1'b0, dvs})
                    : trial[mpi_pkg::ModBits-1:0];
        dq  <= {dq[mpi_pkg::DivBits-2:0], fits};
        cnt <= cnt + 1'b1;
        if (cnt == LastCnt) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign res.done = done;
  assign res.quo  = dq;
  assign res.rem  = rem;

endmodule
`default_nettype wire

[rtl/core/modular_power_and_inverse.sv]
// ----------------------------------------------------------------------------
// modular_power_and_inverse
// Modular power (square-and-multiply) and modular inverse (extended Euclid)
// against one configured modulus, on a shared multiplier and divider.
// ----------------------------------------------------------------------------
// Channels: req (valid/ready) takes mode, value and exponent; rsp
// (valid/ready) returns result and no_inverse, one per request; cfg
// (valid/ready) writes the modulus, always ready; the user must write it
// only while idle; the block does not enforce it. Every modular reduction
// runs through one bit-serial divider. Modulus 0 or 1 gives result 0 without
// the divider. Power: the base reduction, then a squaring per clear and a
// multiply plus a squaring per set exponent bit up to the top set bit.
// Inverse: reduction, then one division per Euclid step (at most about 46).
// One request at a time: req_ready is high only while the sequencer idles.
// A finished result sits in the rsp register; a new request may be taken
// while it waits, and the next result waits until it is taken.
// Reset: modulus returns to 1000000007, rsp_valid drops, the sequencer
// idles. A stalled receiver holds rsp stable and blocks only the next result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module modular_power_and_inverse #(
  parameter int unsigned VALUE_BITS = 63
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         req_valid,
  output logic                              req_ready,
  input  wire mpi_pkg::req_t                req,
  output logic                              rsp_valid,
  input  wire logic                         rsp_ready,
  output mpi_pkg::rsp_t                     rsp,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [mpi_pkg::ModBits-1:0]  cfg_data
);

  localparam int unsigned FB = mpi_pkg::FieldBits;
  localparam int unsigned MB = mpi_pkg::ModBits;
  localparam int unsigned TB = MB + 2;
  localparam logic [FB-1:0] VMask = (FB'(1) << VALUE_BITS) - FB'(1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RED   = 4'd1;
  localparam logic [3:0] S_PSTEP = 4'd2;
  localparam logic [3:0] S_PACC  = 4'd3;
  localparam logic [3:0] S_PSQ   = 4'd4;
  localparam logic [3:0] S_ESTEP = 4'd5;
  localparam logic [3:0] S_EDIV  = 4'd6;
  localparam logic [3:0] S_EUPD  = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0]                  state;
  logic [MB-1:0]               modulus;
  logic [MB-1:0]               m;
  logic                        mode;
  logic [FB-1:0]               expo;
  logic [MB-1:0]               acc;
  logic [MB-1:0]               base;
  logic [MB-1:0]               r0;
  logic [MB-1:0]               r1;
  logic [MB-1:0]               rn;
  logic signed [TB-1:0]        t0;
  logic signed [TB-1:0]        t1;
  logic signed [TB-1:0]        tq;
  logic [MB-1:0]               rslt;
  logic                        flag;
  logic                        div_start;
  logic                        launch;
  logic [mpi_pkg::DivBits-1:0] div_a;
  logic [MB-1:0]               div_b;
  mpi_pkg::div_res_t           div_res;
  logic signed [TB-1:0]        mul_a;
  logic signed [TB-1:0]        mul_b;
  logic signed [2*TB-1:0]      prod;
  logic signed [TB-1:0]        t_fix;

  mpi_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .res      (div_res)
  );

  always_comb begin
    mul_a = $signed({2'b00, base});
    mul_b = $signed({2'b00, base});
    unique case (state)
      S_PSTEP: if (expo[0]) mul_a = $signed({2'b00, acc});
      S_EDIV: begin
        mul_a = t1;
        mul_b = $signed({2'b00, div_res.quo[MB-1:0]});
      end
      default: ;
    endcase
  end

  // divider launch for the next cycle
  always_comb begin
    unique case (state)
      S_IDLE:  launch = req_valid && (modulus > MB'(1));
      S_PSTEP: launch = (expo != '0);
      S_PACC:  launch = div_res.done;
      S_ESTEP: launch = (r1 != '0);
      default: launch = 1'b0;
    endcase
  end

  assign prod  = mul_a * mul_b;
  assign t_fix = (t0 < 0) ? t0 + $signed({2'b00, m}) : t0;

  assign req_ready = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      modulus   <= mpi_pkg::ModulusReset;
      rsp_valid <= 1'b0;
      div_start <= 1'b0;
    end else begin
      div_start <= launch;
      if (cfg_valid) modulus <= cfg_data;
      if (state == S_DONE && (!rsp_valid || rsp_ready)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            mode <= req.mode;
            expo <= req.exponent & VMask;
            m    <= modulus;
            if (modulus <= MB'(1)) begin
              rslt  <= '0;
              flag  <= 1'b0;
              state <= S_DONE;
            end else begin
              div_a <= {1'b0, req.value & VMask};
              div_b <= modulus;
              state <= S_RED;
            end
          end
        end
        S_RED: begin
          if (div_res.done) begin
            if (mode == mpi_pkg::ModeInverse) begin
              r0    <= m;
              r1    <= div_res.rem;
              t0    <= '0;
              t1    <= TB'(1);
              state <= S_ESTEP;
            end else begin
              base  <= div_res.rem;
              acc   <= MB'(1);
              state <= S_PSTEP;
            end
          end
        end
        S_PSTEP: begin
          if (expo == '0) begin
            rslt  <= acc;
            flag  <= 1'b0;
            state <= S_DONE;
          end else begin
            div_a <= prod[mpi_pkg::DivBits-1:0];
            div_b <= m;
            state <= expo[0] ? S_PACC : S_PSQ;
          end
        end
        S_PACC: begin
          if (div_res.done) begin
            acc   <= div_res.rem;
            div_a <= prod[mpi_pkg::DivBits-1:0];
            state <= S_PSQ;
          end
        end
        S_PSQ: begin
          if (div_res.done) begin
            base  <= div_res.rem;
            expo  <= expo >> 1;
            state <= S_PSTEP;
          end
        end
        S_ESTEP: begin
          if (r1 == '0) begin
            flag  <= (r0 != MB'(1));
            rslt  <= (r0 != MB'(1)) ? '0 : t_fix[MB-1:0];
            state <= S_DONE;
          end else begin
            div_a <= {{(mpi_pkg::DivBits-MB){1'b0}}, r0};
            div_b <= r1;
            state <= S_EDIV;
          end
        end
        S_EDIV: begin
          if (div_res.done) begin
            tq    <= prod[TB-1:0];
            rn    <= div_res.rem;
            state <= S_EUPD;
          end
        end
        S_EUPD: begin
          r0    <= r1;
          r1    <= rn;
          t0    <= t1;
          t1    <= t0 - tq;
          state <= S_ESTEP;
        end
        S_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            rsp.result     <= rslt;
            rsp.no_inverse <= flag;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/core/mpi_checker.sv]
// ----------------------------------------------------------------------------
// mpi_checker
// Port-level checks for the modular power and inverse block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "modular_power_and_inverse_defines.svh"
module mpi_checker (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          req_valid,
  input wire logic          req_ready,
  input wire logic          rsp_valid,
  input wire logic          rsp_ready,
  input wire mpi_pkg::rsp_t rsp
);

  `MPI_ASSERT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp), "rsp changed while stalled")
  `MPI_ASSERT(a_flag_zero, clk, rst, rsp_valid && rsp.no_inverse |-> rsp.result == '0, "no_inverse with nonzero result")
  `MPI_ASSERT_RST(a_rst_empty, clk, rst |=> !rsp_valid, "rsp_valid after reset")
  `MPI_ASSERT(a_one_at_a_time, clk, rst, req_valid && req_ready |=> !req_ready, "request taken while busy")

endmodule

bind modular_power_and_inverse mpi_checker u_mpi_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);
`default_nettype wire

[tb/tb_modular_power_and_inverse.sv]
// ----------------------------------------------------------------------------
// tb_modular_power_and_inverse
// Self-checking regression for the modular power and inverse block.
// A directed table covers the operand extremes, every mode and the special
// moduli (one, zero, composite, widest). A random part then runs several
// modulus settings. Expected results come from the table where it has them,
// else from a predictor in the testbench. The sender bursts with gaps, the
// receiver stalls on its own pattern; one long hold-off backs up requests.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_modular_power_and_inverse;

  typedef struct {
    logic [mpi_pkg::ModBits-1:0]   modulus;
    logic                          mode;
    logic [mpi_pkg::FieldBits-1:0] value;
    logic [mpi_pkg::FieldBits-1:0] exponent;
    bit                            typed;
    logic [mpi_pkg::ModBits-1:0]   result;
    logic                          no_inverse;
  } vec_t;

  localparam logic [mpi_pkg::FieldBits-1:0] MaxField = {mpi_pkg::FieldBits{1'b1}};
  localparam int unsigned HoldCycles = 20000;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  mpi_pkg::req_t req;
  logic rsp_valid;
  logic rsp_ready;
  mpi_pkg::rsp_t rsp;
  logic cfg_valid;
  logic cfg_ready;
  logic [mpi_pkg::ModBits-1:0] cfg_data;

  mpi_pkg::rsp_t expected_rsps[$];
  logic [mpi_pkg::ModBits-1:0] cur_modulus;
  int unsigned n_fail;
  int unsigned n_rsp;
  int unsigned n_req;
  int unsigned n_cfg;
  int unsigned burst_left;
  bit held_off;

  modular_power_and_inverse #(.VALUE_BITS(mpi_pkg::FieldBits)) uut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #150_000_000;
    $display("modular_power_and_inverse regression: fail");
    $finish;
  end

  function automatic mpi_pkg::rsp_t modexp_or_inverse(mpi_pkg::req_t r,
                                                      logic [mpi_pkg::ModBits-1:0] m);
    mpi_pkg::rsp_t o;
    longint unsigned mm;
    longint unsigned acc;
    longint unsigned b;
    longint unsigned e;
    longint r0;
    longint r1;
    longint t0;
    longint t1;
    longint q;
    longint rn;
    longint tn;
    o = '0;
    mm = 64'(m);
    if (mm > 64'd1) begin
      if (r.mode == mpi_pkg::ModePower) begin
        acc = 64'd1;
        b = {1'b0, r.value} % mm;
        e = {1'b0, r.exponent};
        while (e != 0) begin
          if (e[0]) acc = (acc * b) % mm;
          b = (b * b) % mm;
          e = e >> 1;
        end
        o.result = acc[mpi_pkg::ModBits-1:0];
      end else begin
        r0 = longint'(mm);
        r1 = longint'({1'b0, r.value} % mm);
        t0 = 0;
        t1 = 1;
        while (r1 != 0) begin
          q = r0 / r1;
          rn = r0 - q * r1;
          tn = t0 - q * t1;
          r0 = r1;
          r1 = rn;
          t0 = t1;
          t1 = tn;
        end
        if (r0 != 1) begin
          o.no_inverse = 1'b1;
        end else begin
          if (t0 < 0) t0 = t0 + longint'(mm);
          o.result = t0[mpi_pkg::ModBits-1:0];
        end
      end
    end
    return o;
  endfunction

  task automatic send_req(mpi_pkg::req_t r, bit typed, mpi_pkg::rsp_t typed_rsp);
    mpi_pkg::rsp_t exp_rsp;
    if (burst_left == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(0, 12)) @(negedge clk);
      burst_left = $urandom_range(1, 10);
    end
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    exp_rsp = typed ? typed_rsp : modexp_or_inverse(r, cur_modulus);
    expected_rsps = {expected_rsps, exp_rsp};
    n_req++;
    burst_left--;
    @(negedge clk);
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    while (expected_rsps.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_modulus(logic [mpi_pkg::ModBits-1:0] m);
    cfg_valid <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cur_modulus = m;
    n_cfg++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic mpi_pkg::req_t random_req(logic [mpi_pkg::ModBits-1:0] m);
    mpi_pkg::req_t r;
    int unsigned k;
    int unsigned w;
    r.mode = 1'($urandom_range(0, 1));
    k = $urandom_range(0, 5);
    case (k)
      0: r.value = mpi_pkg::FieldBits'({$urandom, $urandom});
      1: r.value = mpi_pkg::FieldBits'(m) *
                   mpi_pkg::FieldBits'($urandom_range(0, 1000));
      2: r.value = mpi_pkg::FieldBits'($urandom_range(0, 20));
      default: r.value = mpi_pkg::FieldBits'({$urandom, $urandom} &
                                             ((64'd1 << $urandom_range(1, 40)) - 64'd1));
    endcase
    if ($urandom_range(0, 11) == 0 || r.mode == mpi_pkg::ModeInverse) begin
      r.exponent = mpi_pkg::FieldBits'({$urandom, $urandom});
    end else begin
      w = $urandom_range(0, 12);
      r.exponent = mpi_pkg::FieldBits'({$urandom, $urandom} & ((64'd1 << w) - 64'd1));
    end
    return r;
  endfunction

  // receiver: stall pattern plus one long hold-off
  initial begin
    int unsigned pat;
    int unsigned len;
    rsp_ready = 1'b0;
    @(negedge clk);
    forever begin
      pat = $urandom_range(0, 2);
      len = $urandom_range(20, 400);
      repeat (len) begin
        if (!held_off && n_rsp >= 40) begin
          held_off = 1'b1;
          rsp_ready <= 1'b0;
          repeat (HoldCycles) @(negedge clk);
        end
        case (pat)
          0: rsp_ready <= 1'b1;
          1: rsp_ready <= 1'($urandom_range(0, 1));
          default: rsp_ready <= ($urandom_range(0, 7) == 0);
        endcase
        @(negedge clk);
      end
    end
  end

  // response checker
  always @(posedge clk) begin
    mpi_pkg::rsp_t exp_rsp;
    if (!rst && rsp_valid && rsp_ready) begin
      n_rsp++;
      if (expected_rsps.size() == 0) begin
        $error("unexpected transaction: result %0d no_inverse %0b",
               rsp.result, rsp.no_inverse);
        n_fail++;
      end else begin
        exp_rsp = expected_rsps.pop_front();
        if (rsp.result !== exp_rsp.result) begin
          $error("result: expected %0d actual %0d", exp_rsp.result, rsp.result);
          n_fail++;
        end
        if (rsp.no_inverse !== exp_rsp.no_inverse) begin
          $error("no_inverse: expected %0b actual %0b",
                 exp_rsp.no_inverse, rsp.no_inverse);
          n_fail++;
        end
      end
    end
  end

  initial begin
    vec_t vecs[$];
    logic [mpi_pkg::ModBits-1:0] phase_mods[$];
    mpi_pkg::req_t r;
    mpi_pkg::rsp_t t;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    cur_modulus = mpi_pkg::ModulusReset;
    n_fail = 0;
    n_rsp = 0;
    n_req = 0;
    n_cfg = 0;
    burst_left = 0;
    held_off = 1'b0;

    vecs = '{
      '{mpi_pkg::ModulusReset, mpi_pkg::ModePower, 0, 0, 1, 1, 0},
      '{mpi_pkg::ModulusReset, mpi_pkg::ModePower, 2, 0, 1, 1, 0},
      '{mpi_pkg::ModulusReset, mpi_pkg::ModePower, 2, 10, 1, 1024, 0},
      '{mpi_pkg::ModulusReset, mpi_pkg::ModePower, 1000000007, 5, 1, 0, 0},
      '{mpi_pkg::ModulusReset, mpi_pkg::ModePower, MaxField, MaxField, 0, 0, 0},
      '{mpi_pkg::ModulusReset, mpi_pkg::ModeInverse, 0, 0, 1, 0, 1},
      '{mpi_pkg::ModulusReset, mpi_pkg::ModeInverse, 1, MaxField, 1, 1, 0},
      '{mpi_pkg::ModulusReset, mpi_pkg::ModeInverse, 2, 0, 1, 500000004, 0},
      '{mpi_pkg::ModulusReset, mpi_pkg::ModeInverse, 1000000007, 0, 1, 0, 1},
      '{mpi_pkg::ModulusReset, mpi_pkg::ModeInverse, MaxField, 0, 0, 0, 0},
      '{32'd1, mpi_pkg::ModePower, 5, 3, 1, 0, 0},
      '{32'd1, mpi_pkg::ModeInverse, 5, 0, 1, 0, 0},
      '{32'd1, mpi_pkg::ModeInverse, 0, 0, 1, 0, 0},
      '{32'd0, mpi_pkg::ModePower, 7, 9, 1, 0, 0},
      '{32'd0, mpi_pkg::ModeInverse, 7, 0, 1, 0, 0},
      '{32'd12, mpi_pkg::ModeInverse, 4, 0, 1, 0, 1},
      '{32'd12, mpi_pkg::ModeInverse, 5, 0, 1, 5, 0},
      '{32'd3037000499, mpi_pkg::ModePower, MaxField, MaxField, 0, 0, 0},
      '{32'd3037000499, mpi_pkg::ModeInverse, MaxField, 0, 0, 0, 0},
      '{32'hFFFFFFFF, mpi_pkg::ModePower, MaxField, 12345, 0, 0, 0},
      '{32'hFFFFFFFF, mpi_pkg::ModeInverse, 2, 0, 0, 0, 0},
      '{32'd2, mpi_pkg::ModePower, 3, MaxField, 1, 1, 0},
      '{32'd2, mpi_pkg::ModeInverse, 1, 0, 1, 1, 0}
    };

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    foreach (vecs[i]) begin
      if (vecs[i].modulus !== cur_modulus) begin
        drain();
        write_modulus(vecs[i].modulus);
      end
      r.mode = vecs[i].mode;
      r.value = vecs[i].value;
      r.exponent = vecs[i].exponent;
      t.result = vecs[i].result;
      t.no_inverse = vecs[i].no_inverse;
      send_req(r, vecs[i].typed, t);
    end

    phase_mods = '{32'd3037000499, 32'd97, 32'd1, 32'd360, 32'hFFFFFFFF,
                   32'd2, 32'd0, mpi_pkg::ModulusReset,
                   $urandom_range(3, 32'd3037000499)};
    foreach (phase_mods[p]) begin
      drain();
      write_modulus(phase_mods[p]);
      repeat (30) begin
        r = random_req(cur_modulus);
        send_req(r, 0, '0);
      end
    end

    drain();
    repeat (50) @(posedge clk);
    $display("covered %0d requests, %0d responses, %0d modulus writes", n_req, n_rsp, n_cfg);
    $display("moduli included one, zero, composite, prime and full 32-bit width");
    if (n_fail == 0 && expected_rsps.size() == 0) begin
      $display("modular_power_and_inverse regression: pass");
    end else begin
      $display("modular_power_and_inverse regression: fail");
    end
    $finish;
  end

endmodule
